>>> rtl/jasdp_pkg.sv
// ----------------------------------------------------------------------------
// jasdp_pkg
// Shared constants, types and tables for the joystick scaling and polar block.
// ----------------------------------------------------------------------------
package jasdp_pkg;

  // Default raw sample width.
  localparam int SAMPLE_BITS_DEF = 10;

  // Calibration register and field widths.
  localparam int CAL_W    = 10;
  localparam int DEAD_W   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W    = 8;
  localparam int MAG_W    = 12;
  localparam int ANG_W    = 13;

  // Mapping constants: full span and half span of the scaled axis.
  localparam int SPAN       = 200;
  localparam int FULL_SCALE = 100;

  // Quotient bits kept by the axis divider (plus one overflow bit).
  localparam int QUO_W = 8;

  // Polar conversion.
  localparam int CORDIC_STEPS = 18;
  localparam int SQRT_STEPS   = 12;
  localparam int COORD_SHIFT  = 20;
  localparam int CRD_W        = 30;
  localparam int ZED_W        = 24;
  localparam int SQ_W         = 24;
  localparam int DEG_UNIT     = 65536;
  localparam int ANG_FULL     = 5760;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_MIN     = 3'd0,
    CFG_X_MAX     = 3'd1,
    CFG_Y_MIN     = 3'd2,
    CFG_Y_MAX     = 3'd3,
    CFG_DEAD_ZONE = 3'd4,
    CFG_X_INVERT  = 3'd5,
    CFG_Y_INVERT  = 3'd6
  } cfg_idx_t;

  // Arctangent of 2^-i in units of 2^-16 degree.
  function automatic logic [ZED_W-1:0] atan_tab(input int i);
    logic [ZED_W-1:0] a;
    case (i)
      0:       a = 24'd2949120;
      1:       a = 24'd1740967;
      2:       a = 24'd919879;
      3:       a = 24'd466945;
      4:       a = 24'd234379;
      5:       a = 24'd117304;
      6:       a = 24'd58666;
      7:       a = 24'd29335;
      8:       a = 24'd14668;
      9:       a = 24'd7334;
      10:      a = 24'd3667;
      11:      a = 24'd1833;
      12:      a = 24'd917;
      13:      a = 24'd458;
      14:      a = 24'd229;
      15:      a = 24'd115;
      16:      a = 24'd57;
      17:      a = 24'd29;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/jasdp_axis.sv
// ----------------------------------------------------------------------------
// jasdp_axis
// Scales one raw axis sample onto -100..100 through a pipelined divider,
// then saturates and applies the dead zone, in eleven register stages.
// ----------------------------------------------------------------------------
module jasdp_axis #(
  parameter int SAMPLE_BITS = jasdp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic [SAMPLE_BITS-1:0]               raw,
  input  logic [jasdp_pkg::CAL_W-1:0]          lo,
  input  logic [jasdp_pkg::CAL_W-1:0]          hi,
  input  logic                                 inv,
  input  logic [jasdp_pkg::DEAD_W-1:0]         dead,
  output logic signed [jasdp_pkg::POS_W-1:0]   pos,
  output logic                                 err
);
  import jasdp_pkg::*;

  localparam int RW    = (SAMPLE_BITS > CAL_W) ? SAMPLE_BITS : CAL_W;
  localparam int NW    = RW + 8;
  localparam int DSTG  = QUO_W + 1;

  // Front stage: offset, numerator magnitude, divisor magnitude and signs.
  logic signed [RW:0]    diff;
  logic [RW-1:0]         dabs;
  logic signed [CAL_W:0] den;
  logic [CAL_W-1:0]      dnabs;

  always_comb begin
    diff  = $signed((RW+1)'(raw)) - $signed((RW+1)'(lo));
    dabs  = diff[RW] ? RW'(-diff) : RW'(diff);
    den   = $signed({1'b0, hi}) - $signed({1'b0, lo});
    dnabs = den[CAL_W] ? CAL_W'(-den) : CAL_W'(den);
  end

  logic [NW-1:0]    rem_r [0:DSTG];
  logic [CAL_W-1:0] dn_r  [0:DSTG];
  logic [QUO_W:0]   q_r   [0:DSTG];
  logic             neg_r [0:DSTG];
  logic             inv_r [0:DSTG];
  logic             zro_r [0:DSTG];

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= NW'(dabs) * NW'(SPAN);
      dn_r[0]  <= dnabs;
      q_r[0]   <= '0;
      neg_r[0] <= diff[RW] ^ den[CAL_W] ^ inv;
      inv_r[0] <= inv;
      zro_r[0] <= (den == '0);
    end
  end

  // Restoring division, one quotient bit per stage; the first stage
  // detects a quotient too large for the kept bits.
  genvar j;
  generate
    for (j = 0; j < DSTG; j++) begin : g_div
      logic [NW-1:0] dsh;
      logic          ge;
      always_comb begin
        dsh = NW'(dn_r[j]) << (QUO_W - j);
        ge  = (rem_r[j] >= dsh);
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[j+1] <= ge ? rem_r[j] - dsh : rem_r[j];
          dn_r[j+1]  <= dn_r[j];
          q_r[j+1]   <= {q_r[j][QUO_W-1:0], ge};
          neg_r[j+1] <= neg_r[j];
          inv_r[j+1] <= inv_r[j];
          zro_r[j+1] <= zro_r[j];
        end
      end
    end
  endgenerate

  // Offset, saturation and dead zone.
  logic [QUO_W-1:0]  qc;
  logic signed [9:0] t;
  logic signed [9:0] v;
  logic signed [9:0] vs;
  logic [9:0]        va;
  logic signed [POS_W-1:0] pos_nxt;

  always_comb begin
    qc = q_r[DSTG][QUO_W] ? '1 : q_r[DSTG][QUO_W-1:0];
    t  = neg_r[DSTG] ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
    v  = inv_r[DSTG] ? t + 10'(FULL_SCALE) : t - 10'(FULL_SCALE);
    if (v > $signed(10'(FULL_SCALE))) begin
      vs = 10'(FULL_SCALE);
    end else if (v < -$signed(10'(FULL_SCALE))) begin
      vs = -$signed(10'(FULL_SCALE));
    end else begin
      vs = v;
    end
    va = vs[9] ? 10'(-vs) : 10'(vs);
    if (zro_r[DSTG] || (va <= 10'(dead))) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = POS_W'(vs);
    end
  end

  logic signed [POS_W-1:0] pos_r;
  logic                    err_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r <= pos_nxt;
      err_r <= zro_r[DSTG];
    end
  end

  assign pos = pos_r;
  assign err = err_r;

endmodule

>>> rtl/joystick_axis_scale_deadzone_polar.sv
// ----------------------------------------------------------------------------
// joystick_axis_scale_deadzone_polar
// Scales a raw x/y stick sample, applies the dead zone and gives magnitude
// and angle.
// ----------------------------------------------------------------------------
// One x/y sample pair enters per clock and one result leaves per clock while
// the output is not stalled. Each sample passes eleven stages of axis scaling
// (mainly a one-bit-per-stage divider), one fold stage, eighteen CORDIC
// stages that also carry the twelve square root stages, and the output
// register. A stall on the output freezes the whole pipeline, so in_tready
// follows out_tready while a result is waiting. Calibration registers are
// written through the cfg port and must only change while the block is idle.
module joystick_axis_scale_deadzone_polar #(
  parameter int SAMPLE_BITS = jasdp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: x_raw, y_raw, zero padding
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // out_tdata: x_pos[7:0], y_pos[15:8], magnitude[27:16], angle[40:28], zeros
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [47:0]                      out_tdata,
  // out_tuser: range_error
  output logic [0:0]                       out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [jasdp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jasdp_pkg::CAL_W-1:0]      cfg_data
);
  import jasdp_pkg::*;

  localparam int AX_LAT = QUO_W + 3;

  typedef struct packed {
    logic                    vld;
    logic                    err;
    logic                    nz;
    logic                    xneg;
    logic                    yneg;
    logic                    sw;
    logic signed [POS_W-1:0] xp;
    logic signed [POS_W-1:0] yp;
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
    logic signed [ZED_W-1:0] z;
    logic [SQ_W-1:0]         n;
    logic [SQ_W-1:0]         r;
  } pol_t;

  // Configuration registers.
  logic [CAL_W-1:0]  x_min_r, x_max_r, y_min_r, y_max_r;
  logic [DEAD_W-1:0] dead_r;
  logic              x_inv_r, y_inv_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= '0;
      x_max_r <= '1;
      y_min_r <= '0;
      y_max_r <= '1;
      dead_r  <= '0;
      x_inv_r <= 1'b1;
      y_inv_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_X_MIN:     x_min_r <= cfg_data;
        CFG_X_MAX:     x_max_r <= cfg_data;
        CFG_Y_MIN:     y_min_r <= cfg_data;
        CFG_Y_MAX:     y_max_r <= cfg_data;
        CFG_DEAD_ZONE: dead_r  <= cfg_data[DEAD_W-1:0];
        CFG_X_INVERT:  x_inv_r <= cfg_data[0];
        CFG_Y_INVERT:  y_inv_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The pipeline advances when the output register is empty or being taken.
  logic adv;
  logic out_vld_r;
  assign adv        = !out_vld_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_vld_r;

  // Axis scaling, one unit per axis.
  logic signed [POS_W-1:0] xp, yp;
  logic                    xerr, yerr;

  jasdp_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_x (
    .clk  (clk),
    .adv  (adv),
    .raw  (in_tdata[SAMPLE_BITS-1:0]),
    .lo   (x_min_r),
    .hi   (x_max_r),
    .inv  (x_inv_r),
    .dead (dead_r),
    .pos  (xp),
    .err  (xerr)
  );

  jasdp_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_y (
    .clk  (clk),
    .adv  (adv),
    .raw  (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .lo   (y_min_r),
    .hi   (y_max_r),
    .inv  (y_inv_r),
    .dead (dead_r),
    .pos  (yp),
    .err  (yerr)
  );

  // Valid bits alongside the axis units.
  logic [AX_LAT-1:0] av_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      av_r <= '0;
    end else if (adv) begin
      av_r <= {av_r[AX_LAT-2:0], in_tvalid};
    end
  end

  // Fold stage: squared radius and first-octant vector.
  logic [POS_W-1:0] ax, ay;
  logic [14:0]      xsq, ysq;
  pol_t             fold_nxt;

  always_comb begin
    ax  = xp[POS_W-1] ? POS_W'(-xp) : POS_W'(xp);
    ay  = yp[POS_W-1] ? POS_W'(-yp) : POS_W'(yp);
    xsq = 15'(ax) * 15'(ax);
    ysq = 15'(ay) * 15'(ay);
    fold_nxt      = '0;
    fold_nxt.vld  = av_r[AX_LAT-1];
    fold_nxt.err  = xerr | yerr;
    fold_nxt.xneg = xp[POS_W-1];
    fold_nxt.yneg = yp[POS_W-1];
    fold_nxt.xp   = xp;
    fold_nxt.yp   = yp;
    fold_nxt.n    = SQ_W'({xsq + ysq, 8'h00});
    fold_nxt.nz   = ((xsq + ysq) != 15'd0);
    fold_nxt.sw   = (ay > ax);
    if (ay > ax) begin
      fold_nxt.cx = $signed(CRD_W'(ay) << COORD_SHIFT);
      fold_nxt.cy = $signed(CRD_W'(ax) << COORD_SHIFT);
    end else begin
      fold_nxt.cx = $signed(CRD_W'(ax) << COORD_SHIFT);
      fold_nxt.cy = $signed(CRD_W'(ay) << COORD_SHIFT);
    end
  end

  pol_t pol_r [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r[0].vld <= 1'b0;
    end else if (adv) begin
      pol_r[0] <= fold_nxt;
    end
  end

  // CORDIC vectoring stages; the first stages also run the square root.
  genvar i;
  generate
    for (i = 0; i < CORDIC_STEPS; i++) begin : g_pol
      pol_t            s;
      logic [SQ_W:0]   trial;
      always_comb begin
        s = pol_r[i];
        if (pol_r[i].cy > 0) begin
          s.cx = pol_r[i].cx + (pol_r[i].cy >>> i);
          s.cy = pol_r[i].cy - (pol_r[i].cx >>> i);
          s.z  = pol_r[i].z + $signed(atan_tab(i));
        end else if (pol_r[i].cy < 0) begin
          s.cx = pol_r[i].cx - (pol_r[i].cy >>> i);
          s.cy = pol_r[i].cy + (pol_r[i].cx >>> i);
          s.z  = pol_r[i].z - $signed(atan_tab(i));
        end
        trial = '0;
        if (i < SQRT_STEPS) begin
          trial = (SQ_W+1)'(pol_r[i].r) + ((SQ_W+1)'(1) << (2*(SQRT_STEPS-1-i)));
          if ((SQ_W+1)'(pol_r[i].n) >= trial) begin
            s.n = SQ_W'((SQ_W+1)'(pol_r[i].n) - trial);
            s.r = (pol_r[i].r >> 1) + (SQ_W'(1) << (2*(SQRT_STEPS-1-i)));
          end else begin
            s.r = pol_r[i].r >> 1;
          end
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          pol_r[i+1].vld <= 1'b0;
        end else if (adv) begin
          pol_r[i+1] <= s;
        end
      end
    end
  endgenerate

  // Output stage: rounding of magnitude, angle unfolding and rounding.
  pol_t              lst;
  logic [MAG_W-1:0]  mag;
  logic [25:0]       zc;
  logic [25:0]       q;
  logic [25:0]       a;
  logic [13:0]       k;
  logic [ANG_W-1:0]  ang;

  always_comb begin
    lst = pol_r[CORDIC_STEPS];
    mag = (lst.n > lst.r) ? MAG_W'(lst.r + SQ_W'(1)) : MAG_W'(lst.r);
    if (lst.z < 0) begin
      zc = '0;
    end else if (lst.z > $signed(ZED_W'(45*DEG_UNIT))) begin
      zc = 26'(45*DEG_UNIT);
    end else begin
      zc = 26'(lst.z);
    end
    q = lst.sw ? 26'(90*DEG_UNIT) - zc : zc;
    if (!lst.xneg && !lst.yneg) begin
      a = q;
    end else if (lst.xneg && !lst.yneg) begin
      a = 26'(180*DEG_UNIT) - q;
    end else if (lst.xneg) begin
      a = 26'(180*DEG_UNIT) + q;
    end else begin
      a = 26'(360*DEG_UNIT) - q;
    end
    k = 14'((a + 26'd2048) >> 12);
    if (k >= 14'(ANG_FULL)) begin
      k = k - 14'(ANG_FULL);
    end
    ang = lst.nz ? ANG_W'(k) : '0;
  end

  logic [47:0] out_data_r;
  logic        out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= lst.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {7'd0, ang, mag, lst.yp, lst.xp};
      out_err_r  <= lst.err;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_err_r;

endmodule

>>> test/joystick_axis_scale_deadzone_polar_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joystick_axis_scale_deadzone_polar_tb
// Self-checking testbench for the joystick scaling, dead zone and polar block.
// A directed table covers the calibration extremes, empty ranges and a full
// dead zone. Random samples then run under many calibrations and under
// several patterns of source idling and sink back-pressure. Every output
// transfer is compared with an in-order queue of predicted results.
// ----------------------------------------------------------------------------
module joystick_axis_scale_deadzone_polar_tb;
  import jasdp_pkg::*;

  // A register index that no register answers to.
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
  localparam int ITEMS_PER_CAL = 107;
  localparam int CAL_ROUNDS    = 3;
  localparam int DRAIN_CYCLES  = 40;

  // Arctangent of 2^-i, units of 2^-16 degree.
  localparam longint ATAN_DEG [18] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335, 14668,
    7334, 3667, 1833, 917, 458, 229, 115, 57, 29
  };

  typedef struct packed {
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic [MAG_W-1:0]        magnitude;
    logic [ANG_W-1:0]        angle;
    logic                    range_error;
  } stick_res_t;

  // Calibration sets used by the directed table.
  typedef enum int {CAL_RESET, CAL_EMPTY, CAL_DEAD_FULL, CAL_EXTRAP} cal_set_t;

  typedef struct {
    cal_set_t   cal;
    int         x;
    int         y;
    bit         typed;
    stick_res_t res;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [23:0]                   in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [47:0]                   out_tdata;
  logic [0:0]                    out_tuser;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CAL_W-1:0]              cfg_data = '0;

  // Shadow calibration.
  int cal_x_min, cal_x_max, cal_y_min, cal_y_max, cal_dead, cal_x_inv, cal_y_inv;

  stick_res_t pending_q[$];
  int         mismatches = 0;
  int         send_idle = 0;
  int         recv_stall = 0;

  joystick_axis_scale_deadzone_polar uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Maps one raw sample onto -100..100 with saturation and dead zone.
  function automatic longint scale_sample(int raw, int lo, int hi, int inv,
                                          inout bit err);
    longint den;
    longint v;
    den = longint'(hi) - longint'(lo);
    if (den == 0) begin
      err = 1'b1;
      return 0;
    end
    if (inv != 0) v = ((longint'(raw) - lo) * -200) / den + 100;
    else v = ((longint'(raw) - lo) * 200) / den - 100;
    if (v > 100) v = 100;
    if (v < -100) v = -100;
    if (v <= cal_dead && v >= -cal_dead) v = 0;
    return v;
  endfunction

  // Integer square root rounded to nearest.
  function automatic longint root_nearest(longint n);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 40;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (n > r) r++;
    return r;
  endfunction

  // Direction in 2^-16 degree: octant fold, vectoring rotation, unfold.
  function automatic longint heading(longint x, longint y);
    longint ax, ay, t, cx, cy, nx, ny, z, q;
    bit     swapped;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    swapped = 1'b0;
    z = 0;
    if (ay > ax) begin
      t = ax; ax = ay; ay = t;
      swapped = 1'b1;
    end
    cx = ax <<< COORD_SHIFT;
    cy = ay <<< COORD_SHIFT;
    for (int i = 0; i < 18; i++) begin
      if (cy > 0) begin
        nx = cx + (cy >>> i);
        ny = cy - (cx >>> i);
        z += ATAN_DEG[i];
      end else if (cy < 0) begin
        nx = cx - (cy >>> i);
        ny = cy + (cx >>> i);
        z -= ATAN_DEG[i];
      end else begin
        break;
      end
      cx = nx;
      cy = ny;
    end
    if (z < 0) z = 0;
    if (z > 45 * DEG_UNIT) z = 45 * DEG_UNIT;
    q = swapped ? 90 * DEG_UNIT - z : z;
    if (x >= 0 && y >= 0) return q;
    if (x < 0 && y >= 0) return 180 * DEG_UNIT - q;
    if (x < 0) return 180 * DEG_UNIT + q;
    return 360 * DEG_UNIT - q;
  endfunction

  function automatic stick_res_t predict_stick(int xr, int yr);
    stick_res_t r;
    bit         err;
    longint     xp, yp, sq, k;
    err = 1'b0;
    xp = scale_sample(xr, cal_x_min, cal_x_max, cal_x_inv, err);
    yp = scale_sample(yr, cal_y_min, cal_y_max, cal_y_inv, err);
    sq = xp * xp + yp * yp;
    k = 0;
    if (sq != 0) begin
      k = (heading(xp, yp) + 2048) >>> 12;
      if (k >= ANG_FULL) k -= ANG_FULL;
    end
    r.x_pos = xp[7:0];
    r.y_pos = yp[7:0];
    r.magnitude = MAG_W'(root_nearest(sq * 256));
    r.angle = k[12:0];
    r.range_error = err;
    return r;
  endfunction

  // Register write; cfg_valid is left high for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CAL_W-1:0];
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    case (idx)
      CFG_X_MIN:     cal_x_min = val & 10'h3FF;
      CFG_X_MAX:     cal_x_max = val & 10'h3FF;
      CFG_Y_MIN:     cal_y_min = val & 10'h3FF;
      CFG_Y_MAX:     cal_y_max = val & 10'h3FF;
      CFG_DEAD_ZONE: cal_dead = val & 7'h7F;
      CFG_X_INVERT:  cal_x_inv = val & 1;
      CFG_Y_INVERT:  cal_y_inv = val & 1;
      default: ;
    endcase
  endtask

  task automatic write_cal(input int xl, input int xh, input int yl, input int yh,
                           input int dz, input int xi, input int yi);
    write_reg(CFG_X_MIN, xl);
    write_reg(CFG_X_MAX, xh);
    write_reg(CFG_Y_MIN, yl);
    write_reg(CFG_Y_MAX, yh);
    write_reg(CFG_DEAD_ZONE, dz);
    write_reg(CFG_X_INVERT, xi);
    write_reg(CFG_Y_INVERT, yi);
    write_reg(CFG_NO_REG, $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_set(input cal_set_t s);
    case (s)
      CAL_RESET:     write_cal(0, 1023, 0, 1023, 0, 1, 1);
      CAL_EMPTY:     write_cal(500, 500, 7, 7, 0, 1, 0);
      CAL_DEAD_FULL: write_cal(0, 1023, 1023, 0, 100, 0, 1);
      default:       write_cal(200, 800, 900, 100, 3, 0, 0);
    endcase
  endtask

  // One input transfer; the prediction is queued as the transfer is seen.
  task automatic send_sample(input int x, input int y, input stick_res_t res);
    bit took;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, y[9:0], x[9:0]};
    do begin
      @(negedge clk);
      took = in_tready;
      if (took) pending_q.push_back(res);
      @(posedge clk);
    end while (!took);
  endtask

  // Holds the source off until every pending result has left the block.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_axis(output int lo, output int hi);
    int sel;
    sel = $urandom_range(9);
    lo = $urandom_range(1023);
    if (sel == 0) hi = lo;
    else if (sel == 1) begin
      lo = 0; hi = 1023;
    end else if (sel == 2) begin
      lo = 1023; hi = 0;
    end else hi = $urandom_range(1023);
  endtask

  task automatic random_cal;
    int xl, xh, yl, yh, dz, sel;
    random_axis(xl, xh);
    random_axis(yl, yh);
    sel = $urandom_range(5);
    if (sel == 0) dz = 0;
    else if (sel == 1) dz = 100;
    else if (sel == 2) dz = $urandom_range(1023);
    else dz = $urandom_range(20);
    write_cal(xl, xh, yl, yh, dz, $urandom_range(1023), $urandom_range(1023));
  endtask

  // Sink back-pressure.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  // Output check, sampled mid-cycle ahead of the transfer edge.
  always @(negedge clk) begin
    stick_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.x_pos = out_tdata[7:0];
      got.y_pos = out_tdata[15:8];
      got.magnitude = out_tdata[27:16];
      got.angle = out_tdata[40:28];
      got.range_error = out_tuser[0];
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result differs: x %0d/%0d y %0d/%0d mag %0d/%0d ang %0d/%0d err %0d/%0d",
                     want.x_pos, got.x_pos, want.y_pos, got.y_pos, want.magnitude,
                     got.magnitude, want.angle, got.angle, want.range_error,
                     got.range_error);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("joystick_axis_scale_deadzone_polar: mismatch");
    $finish;
  end

  initial begin
    dir_row_t   rows[$];
    stick_res_t zero_res, res;
    cal_set_t   cur;
    int         x, y, sel;

    zero_res = '0;
    cal_x_min = 0; cal_x_max = 1023; cal_y_min = 0; cal_y_max = 1023;
    cal_dead = 0; cal_x_inv = 1; cal_y_inv = 1;

    // Directed table: the typed rows read all zeros, flagged when both
    // ranges are empty.
    rows = '{
      '{CAL_RESET, 0, 0, 0, zero_res}, '{CAL_RESET, 1023, 1023, 0, zero_res},
      '{CAL_RESET, 0, 1023, 0, zero_res}, '{CAL_RESET, 1023, 0, 0, zero_res},
      '{CAL_RESET, 511, 512, 0, zero_res}, '{CAL_RESET, 512, 511, 0, zero_res},
      '{CAL_RESET, 1, 1022, 0, zero_res}, '{CAL_RESET, 512, 512, 0, zero_res},
      '{CAL_EMPTY, 0, 0, 1, 42'h1}, '{CAL_EMPTY, 1023, 1023, 1, 42'h1},
      '{CAL_EMPTY, 300, 700, 1, 42'h1},
      '{CAL_DEAD_FULL, 0, 0, 1, zero_res}, '{CAL_DEAD_FULL, 1023, 0, 1, zero_res},
      '{CAL_DEAD_FULL, 0, 1023, 1, zero_res}, '{CAL_DEAD_FULL, 400, 611, 1, zero_res},
      '{CAL_EXTRAP, 0, 1023, 0, zero_res}, '{CAL_EXTRAP, 1023, 0, 0, zero_res},
      '{CAL_EXTRAP, 500, 500, 0, zero_res}, '{CAL_EXTRAP, 199, 901, 0, zero_res},
      '{CAL_EXTRAP, 801, 99, 0, zero_res}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset calibration first.
    cur = CAL_RESET;
    foreach (rows[i]) begin
      if (rows[i].cal != cur) begin
        drain();
        cur = rows[i].cal;
        apply_set(cur);
      end
      res = rows[i].typed ? rows[i].res : predict_stick(rows[i].x, rows[i].y);
      send_sample(rows[i].x, rows[i].y, res);
    end

    // Random part: four traffic patterns, several calibrations each.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1) ? 69 : (ph == 3) ? 19 : 0;
      recv_stall = (ph == 2) ? 69 : (ph == 3) ? 19 : 0;
      for (int c = 0; c < CAL_ROUNDS; c++) begin
        drain();
        random_cal();
        for (int n = 0; n < ITEMS_PER_CAL; n++) begin
          sel = $urandom_range(9);
          if (sel < 7) begin
            x = $urandom_range(1023);
            y = $urandom_range(1023);
          end else begin
            // Near the calibration ends, where saturation sets in.
            x = (sel == 7) ? cal_x_min : cal_x_max;
            y = (sel == 9) ? cal_y_min : cal_y_max;
            x = (x + $urandom_range(6) + 1021) % 1024;
            y = (y + $urandom_range(6) + 1021) % 1024;
          end
          if (ph == 1 && c == 1 && n == 50) drain();
          send_sample(x, y, predict_stick(x, y));
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("joystick_axis_scale_deadzone_polar: match");
    end else begin
      $display("joystick_axis_scale_deadzone_polar: mismatch");
    end
    $finish;
  end

endmodule
